### sv/hrt_pkg.sv
// Shared types and widths for the hello reachability tracker.
package hrt_pkg;

  // History length and reset value of the stored sequence number
  localparam int HIST_BITS = 16;
  localparam logic [15:0] SEQ_RESET = 16'hFFFF;

  // Word command codes
  localparam logic CMD_TIMER = 1'b0;
  localparam logic CMD_HELLO = 1'b1;

  // Divider widths: positive numerator fits 31 bits, 10 * interval fits 20 bits
  localparam int NUM_W = 31;
  localparam int DEN_W = 20;
  localparam int CNT_W = $clog2(NUM_W);

  // Input word
  typedef struct packed {
    logic        cmd;
    logic [15:0] hello_seqno;
    logic [15:0] hello_period;
    logic [31:0] now_ms;
  } hrt_in_t;

  // Result word
  typedef struct packed {
    logic        changed;
    logic [15:0] reach_bits;
    logic        link_usable;
    logic        history_empty;
  } hrt_out_t;

endpackage

### sv/hello_reachability_tracker_core.sv
// Top level of the hello reachability tracker for one neighbour.
//
//   channel  ports                          dir  word
//   input    in_valid, in_stall, in_data    in   hrt_in_t  (cmd, seqno, interval, time)
//   result   out_valid, out_stall, out_data out  hrt_out_t (changed, reach, usable, empty)
//
// A hello or a timer check that needs no division passes from IDLE through EVAL
// to FIN, where the result is registered; the next word is taken back in IDLE.
// A timer check with a known interval and positive excess time also runs the
// bit-serial divider, 31 steps, in the DIV state between EVAL and FIN.
// Synchronous active-low reset clears the history and interval state and presets the seqno.
// The result register decouples the sides: a new word is taken while a result
// waits; a stalled result only holds the commit of the following word.
module hello_reachability_tracker_core
  import hrt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hrt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hrt_out_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]  st_r, st_nxt;

  // Tracker state
  logic [15:0] reach_r, reach_nxt;
  logic [15:0] last_r, last_nxt;
  logic        known_r, known_nxt;
  logic [31:0] ref_r, ref_nxt;
  logic [15:0] iv_r, iv_nxt;

  // Held item and timer work
  hrt_in_t     item_r;
  logic [NUM_W-1:0] num_r;
  logic        tmr_go_r;

  hrt_out_t    out_r, out_nxt;
  logic        out_valid_r;

  logic        in_fire, fin_fire, out_fire;
  logic        changed;

  // Timer excess and divisor
  logic [31:0]      elapsed;
  logic [18:0]      iv7;
  logic [33:0]      n_full;
  logic             n_pos;
  logic [DEN_W-1:0] den;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;

  // Hello sequence compare
  logic [15:0]        sdiff;
  logic signed [16:0] m;
  logic [16:0]        neg_m;
  logic [15:0]        r_tmp;

  function automatic logic usable_of(input logic [15:0] r);
    logic res;
    begin
      if (r[15:14] == 2'b11)      res = 1'b1;
      else if (r[15:14] == 2'b00) res = 1'b0;
      else                        res = r[13];
      return res;
    end
  endfunction

  assign in_stall  = (st_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign fin_fire  = (st_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Timer numerator (elapsed - 7*iv) and divisor 10*iv
  always_comb begin
    elapsed   = item_r.now_ms - ref_r;
    iv7       = ({3'b000, iv_r} << 3) - {3'b000, iv_r};
    n_full    = {{2{elapsed[31]}}, elapsed} - {15'd0, iv7};
    n_pos     = !n_full[33] && (n_full != 34'd0);
    den       = ({4'd0, iv_r} << 3) + ({4'd0, iv_r} << 1);
    div_start = (st_r == ST_EVAL) && (item_r.cmd == CMD_TIMER) && (iv_r != 16'd0) && n_pos;
  end

  hrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (n_full[NUM_W-1:0]),
    .den   (den),
    .done  (div_done),
    .quo   (quo),
    .rem   (rem)
  );

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_fire) st_nxt = ST_EVAL;
      ST_EVAL: st_nxt = div_start ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_done) st_nxt = ST_FIN;
      ST_FIN:  if (fin_fire) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // State update at commit
  always_comb begin
    reach_nxt = reach_r;
    last_nxt  = last_r;
    known_nxt = known_r;
    ref_nxt   = ref_r;
    iv_nxt    = iv_r;
    changed   = 1'b0;
    sdiff     = item_r.hello_seqno - last_r;
    m         = $signed({sdiff[15], sdiff}) - 17'sd1;
    neg_m     = 17'd0 - m;
    r_tmp     = reach_r;
    if (item_r.cmd == CMD_TIMER) begin
      if (iv_r == 16'd0) begin
        // no interval known: sixteen hellos missed
        reach_nxt = 16'd0;
        last_nxt  = last_r + 16'(HIST_BITS);
        changed   = 1'b1;
      end else if (tmr_go_r) begin
        reach_nxt = (|quo[NUM_W-1:4]) ? 16'd0 : (reach_r >> quo[3:0]);
        last_nxt  = last_r + quo[15:0];
        ref_nxt   = ref_r + {1'b0, num_r - {{(NUM_W-DEN_W){1'b0}}, rem}};
        // a zero quotient means no hello is overdue yet
        changed   = (quo != '0);
      end
    end else begin
      if (known_r && (reach_r != 16'd0)) begin
        if (m < -17'sd8) begin
          // peer rebooted
          r_tmp   = 16'd0;
          changed = 1'b1;
        end else if (m[16]) begin
          // late or duplicate hello
          r_tmp   = reach_r << neg_m[3:0];
          changed = 1'b1;
        end else if (m != 17'sd0) begin
          r_tmp   = (|m[15:4]) ? 16'd0 : (reach_r >> m[3:0]);
          changed = 1'b1;
        end
      end
      if (item_r.hello_period != 16'd0) begin
        ref_nxt = item_r.now_ms;
        iv_nxt  = item_r.hello_period;
      end
      last_nxt  = item_r.hello_seqno;
      known_nxt = 1'b1;
      reach_nxt = {1'b1, r_tmp[15:1]};
      if (reach_nxt[15:10] != 6'h3F) changed = 1'b1;
    end
    out_nxt.changed       = changed;
    out_nxt.reach_bits    = reach_nxt;
    out_nxt.link_usable   = usable_of(reach_nxt);
    out_nxt.history_empty = (reach_nxt == 16'd0);
  end

  // Control and tracker state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      reach_r     <= 16'd0;
      last_r      <= SEQ_RESET;
      known_r     <= 1'b0;
      ref_r       <= 32'd0;
      iv_r        <= 16'd0;
    end else begin
      st_r <= st_nxt;
      if (fin_fire) begin
        out_valid_r <= 1'b1;
        reach_r     <= reach_nxt;
        last_r      <= last_nxt;
        known_r     <= known_nxt;
        ref_r       <= ref_nxt;
        iv_r        <= iv_nxt;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_data;
    if (st_r == ST_EVAL) begin
      num_r    <= n_full[NUM_W-1:0];
      tmr_go_r <= div_start;
    end
    if (fin_fire) out_r <= out_nxt;
  end

endmodule

### sv/hrt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module hrt_div
  import hrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] qn_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Trial subtract of the partial remainder with the next numerator bit
  always_comb begin
    trial = {rem_r, qn_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Remainder and numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      qn_r  <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      qn_r  <= {qn_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = qn_r;
  assign rem  = rem_r;

endmodule

### sim/testbench.sv
// Self-checking testbench for the hello reachability tracker core.
module testbench
  import hrt_pkg::*;
();

  typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  hrt_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hrt_out_t out_data;

  // Tracker state as the testbench sees it
  logic [15:0] mdl_reach;
  logic [15:0] mdl_last_seq;
  logic        mdl_seq_known;
  logic [31:0] mdl_ref_ms;
  logic [15:0] mdl_iv;

  hrt_out_t    pending_reach[$];
  hrt_out_t    reach_want;
  int unsigned mismatch_count = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_phase_left = 0;

  hello_reachability_tracker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Tracker state after reset
  function automatic void clear_tracker_state();
    mdl_reach     = '0;
    mdl_last_seq  = SEQ_RESET;
    mdl_seq_known = 1'b0;
    mdl_ref_ms    = '0;
    mdl_iv        = '0;
  endfunction

  // Apply one word to the tracker state and return the expected result
  function automatic hrt_out_t predict_reach(hrt_in_t w);
    longint      lost;
    longint      span;
    longint      ivl;
    logic [31:0] dt;
    logic [15:0] dseq;
    bit          upd;
    bit          hold;
    hrt_out_t    r;
    lost = 0;
    upd  = 1'b0;
    hold = 1'b0;
    ivl  = longint'(mdl_iv);
    if (w.cmd == CMD_TIMER) begin
      // missed hellos since the reference time; signed elapsed, truncating division
      if (mdl_iv != 16'd0) begin
        dt   = w.now_ms - mdl_ref_ms;
        span = longint'($signed(dt));
        lost = (span - 7 * ivl) / (10 * ivl);
      end else begin
        lost = HIST_BITS;
      end
      if (lost <= 0) begin
        hold = 1'b1;
      end else begin
        mdl_ref_ms = mdl_ref_ms + 32'(lost * ivl * 10);
      end
    end else begin
      // seqno comparison with 16-bit wrap: reboot or late hello
      if (mdl_seq_known && mdl_reach != 16'd0) begin
        dseq = w.hello_seqno - mdl_last_seq;
        lost = longint'($signed(dseq)) - 1;
        if (lost < -8) begin
          mdl_reach = '0;
          lost = 0;
          upd = 1'b1;
        end else if (lost < 0) begin
          mdl_reach = mdl_reach << (-lost);
          lost = 0;
          upd = 1'b1;
        end
      end
      if (w.hello_period != 16'd0) begin
        mdl_ref_ms = w.now_ms;
        mdl_iv     = w.hello_period;
      end
    end
    if (!hold) begin
      if (lost > 0) begin
        mdl_reach    = (lost >= HIST_BITS) ? 16'd0 : mdl_reach >> lost;
        mdl_last_seq = mdl_last_seq + lost[15:0];
        upd = 1'b1;
      end
      if (w.cmd == CMD_HELLO) begin
        mdl_last_seq  = w.hello_seqno;
        mdl_seq_known = 1'b1;
        mdl_reach     = {1'b1, mdl_reach[15:1]};
        if (mdl_reach[15:10] != 6'h3F) upd = 1'b1;
      end
    end
    r.changed       = upd;
    r.reach_bits    = mdl_reach;
    r.link_usable   = (mdl_reach[15:14] == 2'b11) || ((^mdl_reach[15:14]) && mdl_reach[13]);
    r.history_empty = (mdl_reach == 16'd0);
    return r;
  endfunction

  function automatic hrt_in_t hello_word(logic [15:0] seq, logic [15:0] iv, logic [31:0] now);
    hrt_in_t w;
    w.cmd          = CMD_HELLO;
    w.hello_seqno  = seq;
    w.hello_period = iv;
    w.now_ms       = now;
    return w;
  endfunction

  // Timer word; seqno and interval are don't-care, so fill them at random
  function automatic hrt_in_t timer_word(logic [31:0] now);
    hrt_in_t w;
    w.cmd          = CMD_TIMER;
    w.hello_seqno  = 16'($urandom);
    w.hello_period = 16'($urandom);
    w.now_ms       = now;
    return w;
  endfunction

  function automatic hrt_in_t random_word();
    hrt_in_t w;
    w.cmd          = 1'($urandom_range(0, 1));
    w.hello_seqno  = 16'($urandom);
    w.hello_period = 16'($urandom);
    w.now_ms       = 32'($urandom);
    return w;
  endfunction

  // Send one word in sender bursts; record the expectation on accept
  task automatic send_word(input hrt_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(7, 40));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_reach.push_back(predict_reach(w));
  endtask

  // Timer checks with no interval known yet
  task automatic test_reset_state();
    send_word(timer_word(32'd0));
    send_word(timer_word(32'hFFFF_FFFF));
  endtask

  // First hello without a known seqno, then interval announced
  task automatic test_first_hello();
    send_word(hello_word(16'h0000, 16'h0000, 32'hFFFF_FFFF));
    send_word(hello_word(16'h0001, 16'd100, 32'd1000));
    send_word(hello_word(16'h0002, 16'd100, 32'd2000));
  endtask

  // Duplicate, late, lost, reboot boundaries and seqno wrap
  task automatic test_seqno_cases();
    send_word(hello_word(16'h0002, 16'h0000, 32'd2500));
    send_word(hello_word(16'hFFFE, 16'h0000, 32'd2600));
    send_word(hello_word(16'h0003, 16'h0000, 32'd3000));
    send_word(hello_word(16'h0004, 16'h0000, 32'd3100));
    send_word(hello_word(16'hFFFD, 16'h0000, 32'd3200)); // seven behind: shift only
    send_word(hello_word(16'hFFF5, 16'h0000, 32'd3300)); // eight behind: reboot
    send_word(hello_word(16'hFFFF, 16'h0000, 32'd3400));
    send_word(hello_word(16'h0000, 16'h0000, 32'd3500));
    send_word(hello_word(16'h8000, 16'h0000, 32'd4000)); // half range behind
    send_word(hello_word(16'hFFFF, 16'h0000, 32'd5000)); // half range ahead
  endtask

  // Timer thresholds, backwards time, time wrap, interval extremes
  task automatic test_timer_cases();
    send_word(hello_word(16'h0000, 16'd100, 32'd10000));
    send_word(timer_word(32'd11699));
    send_word(timer_word(32'd11700));
    send_word(timer_word(32'd6000));
    send_word(timer_word(32'd11000 + 32'h8000_0000));
    send_word(hello_word(16'h0001, 16'hFFFF, 32'hFFFF_FFF0));
    send_word(timer_word(32'hFFFF_FFF0 + 32'd13107000));
    send_word(hello_word(16'h0002, 16'd1, 32'h0000_0000));
    send_word(timer_word(32'h7FFF_FFFF));
    send_word(timer_word(32'h7FFF_FFFF));
  endtask

  // Plausible neighbour: mostly in-order hellos and timer checks, some faults
  task automatic test_neighbour_traffic(int count);
    logic [15:0] seq;
    logic [15:0] iv;
    logic [31:0] now;
    int          pick;
    int          skip;
    seq = 16'($urandom);
    iv  = 16'($urandom_range(1, 300));
    now = 32'($urandom);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        seq = seq + 16'd1;
        now = now + 32'(iv) * 32'd10 + 32'($urandom_range(0, 50)) - 32'd25;
        send_word(hello_word(seq, ($urandom_range(0, 2) == 0) ? iv : 16'd0, now));
      end else if (pick < 58) begin
        skip = $urandom_range(2, 20);
        seq = seq + 16'(skip);
        now = now + 32'(skip) * 32'(iv) * 32'd10;
        send_word(hello_word(seq, 16'd0, now));
      end else if (pick < 64) begin
        send_word(hello_word(seq - 16'($urandom_range(0, 9)), 16'd0, now));
      end else if (pick < 67) begin
        seq = 16'($urandom);
        iv  = 16'($urandom_range(1, 300));
        send_word(hello_word(seq, iv, now));
      end else if (pick < 70) begin
        case ($urandom_range(0, 3))
          0:       iv = 16'd1;
          1:       iv = 16'hFFFF;
          2:       iv = 16'($urandom_range(1, 65535));
          default: iv = 16'($urandom_range(1, 300));
        endcase
        seq = seq + 16'd1;
        send_word(hello_word(seq, iv, now));
      end else if (pick < 90) begin
        // timer tick, sometimes after a long silence
        if ($urandom_range(0, 4) == 0)
          now = now + 32'(iv) * 32'd10 * 32'($urandom_range(5, 30));
        else
          now = now + 32'($urandom_range(0, 40 * int'(iv)));
        send_word(timer_word(now));
      end else if (pick < 93) begin
        send_word(timer_word(now - 32'($urandom_range(1, 100000))));
      end else begin
        send_word(random_word());
      end
    end
  endtask

  task automatic test_noise(int count);
    repeat (count) send_word(random_word());
  endtask

  // Receiver stall pattern: phases of no stall, half stall and heavy stall
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= stall_mode_t'($urandom_range(0, 2));
      stall_phase_left <= $urandom_range(20, 200);
      out_stall        <= 1'b0;
    end else begin
      stall_phase_left <= stall_phase_left - 1;
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_HALF: out_stall <= 1'($urandom_range(0, 1));
        default:    out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic check_field(string label, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %h got %h", $time, label, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Result checker: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reach.size() == 0) begin
        $display("%0t: unexpected result word expected none got %h", $time, out_data);
        mismatch_count++;
      end else begin
        reach_want = pending_reach.pop_front();
        check_field("changed", 16'(reach_want.changed), 16'(out_data.changed));
        check_field("reach_bits", reach_want.reach_bits, out_data.reach_bits);
        check_field("link_usable", 16'(reach_want.link_usable), 16'(out_data.link_usable));
        check_field("history_empty", 16'(reach_want.history_empty),
                    16'(out_data.history_empty));
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    clear_tracker_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_first_hello();
    test_seqno_cases();
    test_timer_cases();
    test_neighbour_traffic(690);
    test_noise(60);
    in_valid <= 1'b0;

    // drain, then allow for a full divider pass
    while (pending_reach.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

### filelist.f
sv/hrt_pkg.sv
sv/hrt_div.sv
sv/hello_reachability_tracker_core.sv
sim/testbench.sv
